>>> rtl/core/chr_pkg.sv
package chr_pkg;

    // ring geometry
    localparam int RING_DEPTH = 8192;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int POINT_W  = 32;
    localparam int SERVER_W = 6;
    localparam int STATUS_W = 2;

    // program counter width
    localparam int PC_W = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // request and response payloads
    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [POINT_W-1:0]  ring_point_value;
        logic [SERVER_W-1:0] owner_server;
        logic [POINT_W-1:0]  key_hash;
    } req_t;

    typedef struct packed {
        logic [SERVER_W-1:0] chosen_server;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    points_held;
    } rsp_t;

    // one ring entry in memory
    typedef struct packed {
        logic [POINT_W-1:0]  point;
        logic [SERVER_W-1:0] server;
    } entry_t;

    // datapath actions
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CAPTURE,
        ACT_CLEAR,
        ACT_SEARCH_INIT,
        ACT_SEARCH_STEP,
        ACT_SHIFT_INIT,
        ACT_SHIFT_READ,
        ACT_SHIFT_WRITE,
        ACT_INSERT_WRITE,
        ACT_HIT_READ
    } act_t;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_OP_LOOKUP,
        COND_OP_INSERT,
        COND_FULL,
        COND_EMPTY,
        COND_SEARCH_MORE,
        COND_SEARCH_DONE,
        COND_SHIFT_DONE
    } cond_t;

    // response kinds
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_OK,
        EMIT_EMPTY,
        EMIT_FULL,
        EMIT_SERVER
    } emit_t;

    typedef struct packed {
        act_t            act;
        cond_t           cond;
        emit_t           emit;
        logic [PC_W-1:0] target;
    } ctl_word_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic no_req;
        logic op_lookup;
        logic op_insert;
        logic full;
        logic empty;
        logic search_more;
        logic shift_done;
        logic out_busy;
    } flags_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE        = 5'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH    = 5'd1;
    localparam logic [PC_W-1:0] PC_OP_CHECK    = 5'd2;
    localparam logic [PC_W-1:0] PC_CLEAR       = 5'd3;
    localparam logic [PC_W-1:0] PC_INS_FULL    = 5'd4;
    localparam logic [PC_W-1:0] PC_INS_INIT    = 5'd5;
    localparam logic [PC_W-1:0] PC_INS_STEP    = 5'd6;
    localparam logic [PC_W-1:0] PC_SHIFT_INIT  = 5'd7;
    localparam logic [PC_W-1:0] PC_SHIFT_CHECK = 5'd8;
    localparam logic [PC_W-1:0] PC_SHIFT_READ  = 5'd9;
    localparam logic [PC_W-1:0] PC_SHIFT_WRITE = 5'd10;
    localparam logic [PC_W-1:0] PC_INS_WRITE   = 5'd11;
    localparam logic [PC_W-1:0] PC_LKP_EMPTY   = 5'd12;
    localparam logic [PC_W-1:0] PC_LKP_INIT    = 5'd13;
    localparam logic [PC_W-1:0] PC_LKP_STEP    = 5'd14;
    localparam logic [PC_W-1:0] PC_HIT_READ    = 5'd15;
    localparam logic [PC_W-1:0] PC_EMIT_SERVER = 5'd16;
    localparam logic [PC_W-1:0] PC_EMIT_OK     = 5'd17;
    localparam logic [PC_W-1:0] PC_EMIT_FULL   = 5'd18;
    localparam logic [PC_W-1:0] PC_EMIT_EMPTY  = 5'd19;

    function automatic ctl_word_t mk_cw(act_t a, cond_t c, emit_t e, logic [PC_W-1:0] t);
        ctl_word_t w;
        w.act    = a;
        w.cond   = c;
        w.emit   = e;
        w.target = t;
        return w;
    endfunction

    // microcode store
    function automatic ctl_word_t ucode_word(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        unique case (pc)
            PC_IDLE:        w = mk_cw(ACT_CAPTURE, COND_NO_REQ, EMIT_NONE, PC_IDLE);
            PC_DISPATCH:    w = mk_cw(ACT_NONE, COND_OP_LOOKUP, EMIT_NONE, PC_LKP_EMPTY);
            PC_OP_CHECK:    w = mk_cw(ACT_NONE, COND_OP_INSERT, EMIT_NONE, PC_INS_FULL);
            PC_CLEAR:       w = mk_cw(ACT_CLEAR, COND_ALWAYS, EMIT_NONE, PC_EMIT_OK);
            PC_INS_FULL:    w = mk_cw(ACT_NONE, COND_FULL, EMIT_NONE, PC_EMIT_FULL);
            PC_INS_INIT:    w = mk_cw(ACT_SEARCH_INIT, COND_SEARCH_DONE, EMIT_NONE,
                                      PC_SHIFT_INIT);
            PC_INS_STEP:    w = mk_cw(ACT_SEARCH_STEP, COND_SEARCH_MORE, EMIT_NONE,
                                      PC_INS_STEP);
            PC_SHIFT_INIT:  w = mk_cw(ACT_SHIFT_INIT, COND_NONE, EMIT_NONE, PC_IDLE);
            PC_SHIFT_CHECK: w = mk_cw(ACT_NONE, COND_SHIFT_DONE, EMIT_NONE, PC_INS_WRITE);
            PC_SHIFT_READ:  w = mk_cw(ACT_SHIFT_READ, COND_NONE, EMIT_NONE, PC_IDLE);
            PC_SHIFT_WRITE: w = mk_cw(ACT_SHIFT_WRITE, COND_ALWAYS, EMIT_NONE,
                                      PC_SHIFT_CHECK);
            PC_INS_WRITE:   w = mk_cw(ACT_INSERT_WRITE, COND_ALWAYS, EMIT_NONE, PC_EMIT_OK);
            PC_LKP_EMPTY:   w = mk_cw(ACT_NONE, COND_EMPTY, EMIT_NONE, PC_EMIT_EMPTY);
            PC_LKP_INIT:    w = mk_cw(ACT_SEARCH_INIT, COND_SEARCH_DONE, EMIT_NONE,
                                      PC_HIT_READ);
            PC_LKP_STEP:    w = mk_cw(ACT_SEARCH_STEP, COND_SEARCH_MORE, EMIT_NONE,
                                      PC_LKP_STEP);
            PC_HIT_READ:    w = mk_cw(ACT_HIT_READ, COND_NONE, EMIT_NONE, PC_IDLE);
            PC_EMIT_SERVER: w = mk_cw(ACT_NONE, COND_ALWAYS, EMIT_SERVER, PC_IDLE);
            PC_EMIT_OK:     w = mk_cw(ACT_NONE, COND_ALWAYS, EMIT_OK, PC_IDLE);
            PC_EMIT_FULL:   w = mk_cw(ACT_NONE, COND_ALWAYS, EMIT_FULL, PC_IDLE);
            PC_EMIT_EMPTY:  w = mk_cw(ACT_NONE, COND_ALWAYS, EMIT_EMPTY, PC_IDLE);
            default:        w = mk_cw(ACT_NONE, COND_ALWAYS, EMIT_NONE, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/chr_seq.sv
module chr_seq
    import chr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  flags_t    flags,
    output ctl_word_t cw
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;
    logic            hold;

    // fetch the control word of the current step
    assign cw = ucode_word(pc_reg);

    // jump condition select
    always_comb
    begin
        unique case (cw.cond)
            COND_NONE:        taken = 1'b0;
            COND_ALWAYS:      taken = 1'b1;
            COND_NO_REQ:      taken = flags.no_req;
            COND_OP_LOOKUP:   taken = flags.op_lookup;
            COND_OP_INSERT:   taken = flags.op_insert;
            COND_FULL:        taken = flags.full;
            COND_EMPTY:       taken = flags.empty;
            COND_SEARCH_MORE: taken = flags.search_more;
            COND_SEARCH_DONE: taken = !flags.search_more;
            COND_SHIFT_DONE:  taken = flags.shift_done;
            default:          taken = 1'b1;
        endcase
    end

    // a response step waits while the output register is still held
    assign hold = (cw.emit != EMIT_NONE) && flags.out_busy;

    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> rtl/core/consistent_hash_ring_lookup_top.sv
// Consistent hash ring: a sorted table of 32-bit hash points, each owned by a server.
// Request channel (req_valid, req_stall, req_data) carries clear, insert or lookup;
// response channel (rsp_valid, rsp_stall, rsp_data) returns exactly one response
// per request, in order: chosen server, status and the point count afterwards.
// One request is worked at a time; req_stall is low only while the sequencer idles.
// Steps from request accept to the response step, then back to idle:
//   clear or unused opcode: dispatch, opcode check, clear
//   insert refused when full: dispatch, opcode check, full check
//   lookup: dispatch, empty check (an empty ring stops here), binary search
//     with one memory read per halving, hit read
//   insert: dispatch, opcode check, full check, binary search, shift init, a check,
//     read and write of the ring per point above the new one, a last check, write
// The response sits in an output register, so the block finishes work while the
// receiver stalls; it only holds at the final step if an older response is unread.
// Reset empties the ring (count zero) and drops any pending response; the memory
// itself is not cleared, only entries below the count are ever read.
module consistent_hash_ring_lookup_top
    import chr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    ctl_word_t cw;
    flags_t    flags;

    // ring storage
    entry_t ring_mem [RING_DEPTH];
    entry_t rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    // datapath registers
    req_t             req_reg, req_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid_calc;
    logic [CNT_W-1:0]     idx_dec;
    logic [POINT_W-1:0]   search_key;
    logic                 go_right;
    logic                 search_more;
    logic                 out_busy;
    logic                 rsp_load;

    chr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cw    (cw)
    );

    assign out_busy  = rsp_valid_reg && rsp_stall;
    assign rsp_load  = (cw.emit != EMIT_NONE) && !out_busy;
    assign req_stall = (cw.act != ACT_CAPTURE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // probe compare: upper bound for insert, lower bound for lookup
    assign search_key = (req_reg.opcode == OP_INSERT) ? req_reg.ring_point_value
                                                      : req_reg.key_hash;
    assign go_right   = (req_reg.opcode == OP_INSERT) ? (rd_data_reg.point <= search_key)
                                                      : (rd_data_reg.point < search_key);
    assign idx_dec    = idx_reg - 1'b1;

    // datapath control
    always_comb
    begin
        req_next   = req_reg;
        total_next = total_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_addr    = mid_reg[ADDR_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = lo_reg[ADDR_W-1:0];
        wr_data    = rd_data_reg;

        case (cw.act)
            ACT_CAPTURE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                end
            end
            ACT_CLEAR:
            begin
                if (req_reg.opcode == OP_CLEAR)
                begin
                    total_next = '0;
                end
            end
            ACT_SEARCH_INIT:
            begin
                lo_next = '0;
                hi_next = total_reg;
            end
            ACT_SEARCH_STEP:
            begin
                if (go_right)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            ACT_SHIFT_INIT:
            begin
                idx_next = total_reg;
            end
            ACT_SHIFT_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_dec[ADDR_W-1:0];
            end
            ACT_SHIFT_WRITE:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[ADDR_W-1:0];
                wr_data  = rd_data_reg;
                idx_next = idx_dec;
            end
            ACT_INSERT_WRITE:
            begin
                wr_en          = 1'b1;
                wr_addr        = lo_reg[ADDR_W-1:0];
                wr_data.point  = req_reg.ring_point_value;
                wr_data.server = req_reg.owner_server;
                total_next     = total_reg + 1'b1;
            end
            ACT_HIT_READ:
            begin
                // wrap to the lowest point when every point lies below the key
                rd_en   = 1'b1;
                rd_addr = (lo_reg == total_reg) ? '0 : lo_reg[ADDR_W-1:0];
            end
            default:
            begin
            end
        endcase

        // next probe from the updated bounds
        mid_sum     = {1'b0, lo_next} + {1'b0, hi_next};
        mid_calc    = mid_sum[CNT_W:1];
        search_more = (lo_next < hi_next);
        mid_next    = mid_reg;
        if ((cw.act == ACT_SEARCH_INIT) || (cw.act == ACT_SEARCH_STEP))
        begin
            mid_next = mid_calc;
            rd_en    = search_more;
            rd_addr  = mid_calc[ADDR_W-1:0];
        end
    end

    // status to the sequencer
    always_comb
    begin
        flags.no_req      = !req_valid;
        flags.op_lookup   = (req_reg.opcode == OP_LOOKUP);
        flags.op_insert   = (req_reg.opcode == OP_INSERT);
        flags.full        = (total_reg == CNT_W'(RING_DEPTH));
        flags.empty       = (total_reg == '0);
        flags.search_more = search_more;
        flags.shift_done  = (idx_reg == lo_reg);
        flags.out_busy    = out_busy;
    end

    // response build
    always_comb
    begin
        rsp_next               = rsp_reg;
        rsp_valid_next         = rsp_valid_reg && rsp_stall;
        if (rsp_load)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.points_held   = total_reg;
            rsp_next.chosen_server = '0;
            case (cw.emit)
                EMIT_SERVER:
                begin
                    rsp_next.status        = ST_OK;
                    rsp_next.chosen_server = rd_data_reg.server;
                end
                EMIT_EMPTY: rsp_next.status = ST_EMPTY;
                EMIT_FULL:  rsp_next.status = ST_FULL;
                default:    rsp_next.status = ST_OK;
            endcase
        end
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        mid_reg <= mid_next;
        rsp_reg <= rsp_next;
    end

    // point count never passes capacity
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(RING_DEPTH))
        else $error("point count above ring depth");

    // search window stays well formed
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search bounds crossed");

    // an accepted request always takes the sequencer out of idle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (cw.act != ACT_CAPTURE))
        else $error("sequencer stayed idle after accept");

    // shifting never overwrites at or below the insert position
    a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.act == ACT_SHIFT_WRITE) |-> (idx_reg > lo_reg))
        else $error("shift write below insert position");

endmodule

>>> test/consistent_hash_ring_lookup_checker.sv
`timescale 1ns / 1ps

module consistent_hash_ring_lookup_checker
    import chr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp_data,
    output int   fail_count,
    output int   pending
);

    // shadow copy of the sorted ring
    logic [POINT_W-1:0]  shadow_point [RING_DEPTH];
    logic [SERVER_W-1:0] shadow_owner [RING_DEPTH];
    int unsigned         shadow_total;

    // responses predicted but not yet seen, oldest first
    rsp_t awaited_rsp_q[$];

    initial
    begin
        shadow_total = 0;
        fail_count   = 0;
        pending      = 0;
    end

    // count of points below v (strict) or not above v
    function automatic int unsigned ring_rank(logic [POINT_W-1:0] v, bit strict);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = shadow_total;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (strict ? (shadow_point[mid] < v) : (shadow_point[mid] <= v))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // apply one request to the shadow ring and form its response
    function automatic rsp_t ring_apply(req_t r);
        rsp_t        o;
        int unsigned pos;
        o = '0;
        case (r.opcode)
            OP_CLEAR:
                shadow_total = 0;
            OP_INSERT:
                if (shadow_total >= RING_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    pos = ring_rank(r.ring_point_value, 1'b0);
                    for (int unsigned i = shadow_total; i > pos; i--)
                    begin
                        shadow_point[i] = shadow_point[i-1];
                        shadow_owner[i] = shadow_owner[i-1];
                    end
                    shadow_point[pos] = r.ring_point_value;
                    shadow_owner[pos] = r.owner_server;
                    shadow_total++;
                end
            OP_LOOKUP:
                if (shadow_total == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    pos = ring_rank(r.key_hash, 1'b1);
                    // past the last point wraps to the lowest one
                    if (pos >= shadow_total)
                        pos = 0;
                    o.chosen_server = shadow_owner[pos];
                end
            default:
                ;
        endcase
        o.points_held = shadow_total[CNT_W-1:0];
        return o;
    endfunction

    // compare responses, then predict for the new request
    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected response server=%0d status=%0d held=%0d",
                             $time, rsp_data.chosen_server, rsp_data.status,
                             rsp_data.points_held);
                end
                else
                begin
                    want = awaited_rsp_q.pop_front();
                    if (rsp_data.chosen_server !== want.chosen_server ||
                        rsp_data.status !== want.status ||
                        rsp_data.points_held !== want.points_held)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected server=%0d status=%0d held=%0d",
                                 $time, want.chosen_server, want.status, want.points_held);
                        $display("%0t:          actual   server=%0d status=%0d held=%0d",
                                 $time, rsp_data.chosen_server, rsp_data.status,
                                 rsp_data.points_held);
                    end
                end
            end
            if (req_valid && !req_stall)
                awaited_rsp_q.push_back(ring_apply(req_data));
        end
        pending = awaited_rsp_q.size();
    end

endmodule

>>> test/tb_consistent_hash_ring_lookup_top.sv
`timescale 1ns / 1ps

module tb_consistent_hash_ring_lookup_top;
    import chr_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1400;
    localparam int FILL_POINTS  = 256;
    localparam int LONG_HOLD    = 300;
    localparam int WD_LIMIT     = 100000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    int fail_count;
    int pending;

    // idling controls shared by sender and receiver
    bit hold_rsp;
    bit calm;
    int hold_done;

    // per-opcode request tallies
    int n_clear;
    int n_insert;
    int n_lookup;
    int n_spare;

    // points placed since the last clear, used to aim keys
    logic [POINT_W-1:0] placed_points[$];

    consistent_hash_ring_lookup_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    consistent_hash_ring_lookup_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // idle length: mostly short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t make_req(logic [OP_W-1:0] op, logic [POINT_W-1:0] pt,
                                      logic [SERVER_W-1:0] srv, logic [POINT_W-1:0] key);
        req_t r;
        r.opcode           = op;
        r.ring_point_value = pt;
        r.owner_server     = srv;
        r.key_hash         = key;
        return r;
    endfunction

    // point value: duplicates, extremes, a tight cluster or anything
    function automatic logic [POINT_W-1:0] pick_point();
        int r;
        r = $urandom_range(0, 99);
        if (placed_points.size() != 0 && r < 30)
            return placed_points[$urandom_range(0, placed_points.size() - 1)];
        if (r < 40)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        if (r < 60)
            return $urandom_range(0, 15);
        return $urandom;
    endfunction

    // key hash: hits, near misses, extremes, cluster or anything
    function automatic logic [POINT_W-1:0] pick_key();
        int r;
        logic [POINT_W-1:0] k;
        r = $urandom_range(0, 99);
        if (placed_points.size() != 0 && r < 30)
            return placed_points[$urandom_range(0, placed_points.size() - 1)];
        if (placed_points.size() != 0 && r < 45)
        begin
            k = placed_points[$urandom_range(0, placed_points.size() - 1)];
            return $urandom_range(0, 1) ? k + 1 : k - 1;
        end
        if (r < 55)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        if (r < 65)
            return $urandom_range(0, 15);
        return $urandom;
    endfunction

    // offer one request after a gap and wait until it is taken
    task automatic offer_request(input req_t r);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        case (r.opcode)
            OP_CLEAR:  n_clear++;
            OP_INSERT: n_insert++;
            OP_LOOKUP: n_lookup++;
            default:   n_spare++;
        endcase
    endtask

    // receiver: random stall stretches, plus long holds on demand
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        hold_done = 0;
        forever
        begin
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                for (int i = 0; i < LONG_HOLD; i++)
                begin
                    @(negedge clk);
                    rsp_stall <= 1'b1;
                end
                hold_done++;
            end
            else
            begin
                n = pick_idle();
                for (int i = 0; i < n; i++)
                begin
                    @(negedge clk);
                    rsp_stall <= 1'b1;
                end
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    @(negedge clk);
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WD_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WD_LIMIT);
        $display("** consistent_hash_ring_lookup_top: FAILED **");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [POINT_W-1:0] pv;
        int sel;
        int target;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        hold_rsp  = 1'b0;
        calm      = 1'b0;
        n_clear   = 0;
        n_insert  = 0;
        n_lookup  = 0;
        n_spare   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty ring, extremes, equal points, wrap, unused opcode
        offer_request(make_req(OP_LOOKUP, 32'h0, 6'd0, 32'h0));
        offer_request(make_req(OP_SPARE, 32'h0, 6'd0, 32'h0));
        offer_request(make_req(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h0));
        offer_request(make_req(OP_INSERT, 32'h0, 6'd0, 32'hFFFF_FFFF));
        offer_request(make_req(OP_INSERT, 32'h8000_0000, 6'd21, 32'h0));
        offer_request(make_req(OP_INSERT, 32'h8000_0000, 6'd42, 32'hFFFF_FFFF));
        offer_request(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'h0));
        offer_request(make_req(OP_LOOKUP, 32'h0, 6'd0, 32'hFFFF_FFFF));
        offer_request(make_req(OP_LOOKUP, 32'h0, 6'd0, 32'h8000_0000));
        offer_request(make_req(OP_LOOKUP, 32'h0, 6'd0, 32'h7FFF_FFFF));
        offer_request(make_req(OP_LOOKUP, 32'h0, 6'd0, 32'h8000_0001));
        offer_request(make_req(OP_SPARE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
        offer_request(make_req(OP_CLEAR, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
        offer_request(make_req(OP_LOOKUP, 32'h0, 6'd0, 32'h0));
        offer_request(make_req(OP_INSERT, 32'h10, 6'd5, 32'hA5A5_A5A5));
        offer_request(make_req(OP_LOOKUP, 32'h5A5A_5A5A, 6'd42, 32'h11));
        offer_request(make_req(OP_LOOKUP, 32'h0, 6'd0, 32'hFFFF_FFFF));
        offer_request(make_req(OP_LOOKUP, 32'h0, 6'd0, 32'h10));
        offer_request(make_req(OP_CLEAR, 32'h0, 6'd0, 32'h0));

        // grow a larger ring in ascending order so nothing has to move
        calm = 1'b1;
        for (int i = 0; i < FILL_POINTS; i++)
        begin
            pv = 32'(i) << 19;
            offer_request(make_req(OP_INSERT, pv, 6'(i), $urandom));
        end
        calm = 1'b0;
        // a long shift near the bottom, an append at the top, lookups on the larger ring
        offer_request(make_req(OP_INSERT, 32'h0001_2345, 6'd9, $urandom));
        offer_request(make_req(OP_INSERT, 32'hFFFF_FFFF, 6'd63, $urandom));
        offer_request(make_req(OP_LOOKUP, $urandom, 6'($urandom), 32'h0));
        offer_request(make_req(OP_LOOKUP, $urandom, 6'($urandom), 32'hFFFF_FFFF));
        offer_request(make_req(OP_SPARE, $urandom, 6'($urandom), $urandom));
        for (int i = 0; i < 12; i++)
            offer_request(make_req(OP_LOOKUP, $urandom, 6'($urandom), $urandom));
        offer_request(make_req(OP_CLEAR, $urandom, 6'($urandom), $urandom));

        // random: grow small rings, probe them, clear and repeat
        target = 8;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400 || n == 1200)
                hold_rsp = 1'b1;
            calm = (n >= 800 && n < 950);
            sel = $urandom_range(0, 99);
            if (sel < 3)
            begin
                offer_request(make_req(OP_CLEAR, $urandom, 6'($urandom), $urandom));
                placed_points.delete();
                target = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 220)
                                                     : $urandom_range(1, 40);
            end
            else if (sel < 6)
                offer_request(make_req(OP_SPARE, $urandom, 6'($urandom), $urandom));
            else if (sel < 50 && placed_points.size() < target)
            begin
                pv = pick_point();
                offer_request(make_req(OP_INSERT, pv, 6'($urandom), $urandom));
                placed_points.push_back(pv);
            end
            else
                offer_request(make_req(OP_LOOKUP, $urandom, 6'($urandom), pick_key()));
        end
        calm = 1'b0;
        @(negedge clk);
        req_valid <= 1'b0;

        // drain, then let the block settle
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("covered %0d requests: %0d inserts, %0d lookups, %0d clears, %0d unused",
                 n_clear + n_insert + n_lookup + n_spare, n_insert, n_lookup, n_clear,
                 n_spare);
        $display("ring grown in order to %0d points once, %0d long response holds",
                 FILL_POINTS, hold_done);
        if (fail_count == 0)
            $display("** consistent_hash_ring_lookup_top: PASSED **");
        else
            $display("** consistent_hash_ring_lookup_top: FAILED **");
        $finish;
    end

endmodule
